// ===== hw/rtl/escf_pkg.sv =====
// Shared types and constants for the second chance frame table.
`timescale 1ns / 1ps
package escf_pkg;
	localparam int unsigned CFG_W = 8;
	localparam int unsigned OWNER_W = 8;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned FRAME_COUNT = 64;
	localparam int unsigned OWNER_BITS = 8;
	localparam logic [CFG_W-1:0] MAX_PROC_RESET = 8'd16;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef enum logic {
		REQ_ACCESS = 1'b0,
		REQ_TERMINATE = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_COMMIT,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_term;
	} dp_sts_t;
endpackage

// ===== hw/rtl/escf_if.sv =====
// Valid/ready channel interfaces for request, result and configuration words.
`timescale 1ns / 1ps
interface escf_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] owner_id;
	logic [31:0] byte_address;
	logic is_write;
	modport source (output valid, req_type, owner_id, byte_address, is_write, input ready);
	modport sink (input valid, req_type, owner_id, byte_address, is_write, output ready);
endinterface

interface escf_rsp_if;
	logic valid;
	logic ready;
	logic granted;
	logic hit;
	logic fault;
	logic writeback;
	logic [5:0] frame_index;
	modport source (output valid, granted, hit, fault, writeback, frame_index, input ready);
	modport sink (input valid, granted, hit, fault, writeback, frame_index, output ready);
endinterface

interface escf_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/escf_ctrl.sv =====
// Sequencer for one request: load, scan, decide, commit, present result.
`timescale 1ns / 1ps
module escf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output escf_pkg::dp_cmd_t cmd
);
	import escf_pkg::*;
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_SCAN: cmd.scan = 1'b1;
			ST_DECIDE: cmd.out_load = 1'b1;
			ST_COMMIT: cmd.commit = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== hw/rtl/escf_dp.sv =====
// Frame table datapath: match/free/class masks, circular priority pick, update.
`timescale 1ns / 1ps
module escf_dp #(
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  escf_pkg::dp_cmd_t cmd,
	input  logic req_type,
	input  logic [7:0] owner_id,
	input  logic [31:0] byte_address,
	input  logic is_write,
	input  logic [7:0] max_proc,
	output logic granted,
	output logic hit,
	output logic fault,
	output logic writeback,
	output logic [5:0] frame_index
);
	import escf_pkg::*;
	localparam int unsigned FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int unsigned PW = 32 - PAGE_SHIFT;
	localparam int unsigned N = FRAME_COUNT;

	logic [OWNER_BITS-1:0] own_q [N];
	logic [PW-1:0] page_q [N];
	logic [N-1:0] ref_q, dirty_q;
	logic [FW-1:0] hand_q;
	logic [7:0] count_q;

	logic term_q, wr_q;
	logic [OWNER_BITS-1:0] rown_q;
	logic [PW-1:0] rpage_q;

	// scan-stage masks
	logic [N-1:0] hitm_q, freem_q, ownm_q;
	logic [N-1:0] cls_q [4];

	// decision registers
	logic acc_ok_q, inc_q, hit_d_q, free_d_q, vict_q;
	logic [FW-1:0] pick_q;

	logic [N-1:0] hitm, freem, ownm;
	logic [N-1:0] clsm [4];

	always_comb begin
		for (int f = 0; f < N; f++) begin
			ownm[f] = (own_q[f] == rown_q);
			freem[f] = (own_q[f] == '0);
			hitm[f] = !freem[f] && (page_q[f] == rpage_q);
			for (int c = 0; c < 4; c++)
				clsm[c][f] = (ref_q[f] == c[1]) && (dirty_q[f] == c[0]);
		end
	end

	// circular first-set after the hand
	function automatic logic [FW:0] first_after(input logic [N-1:0] m, input logic [FW-1:0] h);
		logic [FW:0] r;
		logic [FW-1:0] idx;
		r = '0;
		for (int i = N - 1; i >= 0; i--) begin
			idx = FW'((32'(h) + 1 + i) % N);
			if (m[idx]) r = {1'b1, idx};
		end
		return r;
	endfunction

	logic [FW:0] ph, pf, pc0, pc1, pc2, pc3;
	logic known;
	always_comb begin
		ph = first_after(hitm_q, hand_q);
		pf = first_after(freem_q, hand_q);
		pc0 = first_after(cls_q[0], hand_q);
		pc1 = first_after(cls_q[1], hand_q);
		pc2 = first_after(cls_q[2], hand_q);
		pc3 = first_after(cls_q[3], hand_q);
		known = |ownm_q;
	end

	logic [N-1:0] between;
	always_comb begin
		for (int f = 0; f < N; f++) begin
			logic [FW-1:0] df, dv;
			df = FW'((32'(f) + N - 32'(hand_q) - 1) % N);
			dv = FW'((32'(pick_q) + N - 32'(hand_q) - 1) % N);
			between[f] = (df < dv);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			term_q <= req_type;
			wr_q <= is_write;
			rown_q <= owner_id[OWNER_BITS-1:0];
			rpage_q <= byte_address[31:PAGE_SHIFT];
		end
		if (cmd.scan) begin
			hitm_q <= hitm;
			freem_q <= freem;
			ownm_q <= ownm;
			for (int c = 0; c < 4; c++) cls_q[c] <= clsm[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ok_q <= 1'b0; inc_q <= 1'b0; hit_d_q <= 1'b0;
			free_d_q <= 1'b0; vict_q <= 1'b0; pick_q <= '0;
			granted <= 1'b0; hit <= 1'b0; fault <= 1'b0;
			writeback <= 1'b0; frame_index <= '0;
		end else if (cmd.out_load) begin
			logic ok, nz, wb;
			logic [FW-1:0] sel;
			nz = (rown_q != '0);
			ok = nz && (known || (count_q < max_proc));
			wb = 1'b0;
			// victim dirty bit is the low bit of its class
			priority if (ph[FW]) sel = ph[FW-1:0];
			else if (pf[FW]) sel = pf[FW-1:0];
			else if (pc0[FW]) sel = pc0[FW-1:0];
			else if (pc1[FW]) begin
				sel = pc1[FW-1:0]; wb = 1'b1;
			end else if (pc2[FW]) sel = pc2[FW-1:0];
			else begin
				sel = pc3[FW-1:0]; wb = 1'b1;
			end
			acc_ok_q <= !term_q && ok;
			inc_q <= !term_q && ok && !known;
			hit_d_q <= ph[FW];
			free_d_q <= !ph[FW] && pf[FW];
			vict_q <= !ph[FW] && !pf[FW];
			pick_q <= sel;
			granted <= term_q || ok;
			hit <= !term_q && ok && ph[FW];
			fault <= !term_q && ok && !ph[FW];
			writeback <= !term_q && ok && !ph[FW] && !pf[FW] && wb;
			frame_index <= (!term_q && ok) ? 6'(sel) : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < N; f++) own_q[f] <= '0;
			ref_q <= '0; dirty_q <= '0; hand_q <= '0; count_q <= '0;
		end else if (cmd.commit) begin
			if (term_q) begin
				if (rown_q != '0) begin
					for (int f = 0; f < N; f++)
						if (ownm_q[f]) begin
							own_q[f] <= '0; ref_q[f] <= 1'b0; dirty_q[f] <= 1'b0;
						end
					if (count_q != '0) count_q <= count_q - 8'd1;
				end
			end else if (acc_ok_q) begin
				if (inc_q && count_q != COUNT_MAX) count_q <= count_q + 8'd1;
				if (vict_q) begin
					// clear second chance on frames the hand sweeps past
					ref_q <= ref_q & ~between & ~(N'(1) << pick_q);
					hand_q <= pick_q;
				end else
					ref_q[pick_q] <= hit_d_q;
				own_q[pick_q] <= rown_q;
				dirty_q[pick_q] <= wr_q;
			end
		end
	end

	always_ff @(posedge clk)
		if (cmd.commit && !term_q && acc_ok_q && !hit_d_q) page_q[pick_q] <= rpage_q;
endmodule

// ===== hw/rtl/enhanced_second_chance_frames_top.sv =====
// Top level of the enhanced second chance frame table.
//  channel | dir | word
//  req     | in  | req_type, owner_id, byte_address, is_write
//  rsp     | out | granted, hit, fault, writeback, frame_index
//  cfg     | in  | max_processes
// A request goes through take, scan of all frames, circular priority pick,
// table update and result. The next word is taken once the result
// has gone, so one request is in flight at a time.
// Reset clears owners, referenced and dirty bits, hand and count at once.
// A stalled result holds the sequencer; cfg is always ready.
`timescale 1ns / 1ps
module enhanced_second_chance_frames_top #(
	parameter int unsigned PAGE_SHIFT = 12
) (
	input logic clk,
	input logic arst_n,
	escf_req_if.sink req,
	escf_rsp_if.source rsp,
	escf_cfg_if.sink cfg
);
	import escf_pkg::*;
	dp_cmd_t cmd;
	logic [CFG_W-1:0] max_proc_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_proc_q <= MAX_PROC_RESET;
		else if (cfg.valid) max_proc_q <= cfg.data;
	end

	escf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(cmd)
	);

	escf_dp #(.PAGE_SHIFT(PAGE_SHIFT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_type(req.req_type),
		.owner_id(req.owner_id), .byte_address(req.byte_address),
		.is_write(req.is_write), .max_proc(max_proc_q), .granted(rsp.granted),
		.hit(rsp.hit), .fault(rsp.fault), .writeback(rsp.writeback),
		.frame_index(rsp.frame_index)
	);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.fault)) else $error("hit and fault together");
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.writeback |-> rsp.fault) else $error("writeback without fault");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready) else $error("took a second word");
endmodule

// ===== bench/escf_checker.sv =====
// Checker for the frame table: watches request, result and config words, predicts and compares.
`timescale 1ns / 1ps
module escf_checker
	import escf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	escf_req_if.sink req,
	escf_rsp_if.sink rsp,
	escf_cfg_if.sink cfg,
	output int fail_count,
	output int pending
);
	localparam int NF = 64;

	typedef struct packed {
		logic granted;
		logic hit;
		logic fault;
		logic writeback;
		logic [5:0] frame_index;
	} outcome_t;

	logic [7:0] own_tbl [NF];
	logic [19:0] page_tbl [NF];
	logic ref_tbl [NF];
	logic dirty_tbl [NF];
	logic [5:0] hand;
	logic [7:0] active_owners;
	logic [7:0] proc_limit;
	outcome_t outcome_q[$];

	assign pending = outcome_q.size();

	function automatic outcome_t serve(input req_kind_t kind, input logic [7:0] who,
			input logic [31:0] addr, input logic wr);
		outcome_t o;
		logic [19:0] pg;
		logic held;
		int f, g, c;
		o = '0;
		pg = addr[31:12];
		if (kind == REQ_TERMINATE) begin
			o.granted = 1'b1;
			if (who == 0)
				return o;
			for (f = 0; f < NF; f++)
				if (own_tbl[f] == who) begin
					own_tbl[f] = '0;
					ref_tbl[f] = 1'b0;
					dirty_tbl[f] = 1'b0;
				end
			if (active_owners > 0)
				active_owners--;
			return o;
		end
		if (who == 0)
			return o;
		held = 1'b0;
		for (f = 0; f < NF; f++)
			if (own_tbl[f] == who)
				held = 1'b1;
		if (!held) begin
			if (active_owners >= proc_limit)
				return o;
			if (active_owners < COUNT_MAX)
				active_owners++;
		end
		o.granted = 1'b1;
		for (int i = 0; i < NF; i++) begin
			f = (hand + 1 + i) % NF;
			if (own_tbl[f] != 0 && page_tbl[f] == pg) begin
				own_tbl[f] = who;
				ref_tbl[f] = 1'b1;
				dirty_tbl[f] = wr;
				o.hit = 1'b1;
				o.frame_index = f[5:0];
				return o;
			end
		end
		for (int i = 0; i < NF; i++) begin
			f = (hand + 1 + i) % NF;
			if (own_tbl[f] == 0) begin
				own_tbl[f] = who;
				page_tbl[f] = pg;
				ref_tbl[f] = 1'b0;
				dirty_tbl[f] = wr;
				o.fault = 1'b1;
				o.frame_index = f[5:0];
				return o;
			end
		end
		for (c = 0; c < 4; c++)
			for (int i = 0; i < NF; i++) begin
				f = (hand + 1 + i) % NF;
				if (ref_tbl[f] == c[1] && dirty_tbl[f] == c[0]) begin
					// clear referenced bits passed over on the way to the victim
					for (int j = 0; j < NF; j++) begin
						g = (hand + 1 + j) % NF;
						if (g == f)
							break;
						ref_tbl[g] = 1'b0;
					end
					o.writeback = dirty_tbl[f];
					own_tbl[f] = who;
					page_tbl[f] = pg;
					ref_tbl[f] = 1'b0;
					dirty_tbl[f] = wr;
					hand = f[5:0];
					o.fault = 1'b1;
					o.frame_index = f[5:0];
					return o;
				end
			end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			for (int f = 0; f < NF; f++) begin
				own_tbl[f] = '0;
				page_tbl[f] = '0;
				ref_tbl[f] = 1'b0;
				dirty_tbl[f] = 1'b0;
			end
			hand = '0;
			active_owners = '0;
			proc_limit = MAX_PROC_RESET;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				proc_limit = cfg.data;
			if (req.valid && req.ready)
				outcome_q.push_back(serve(req_kind_t'(req.req_type), req.owner_id,
					req.byte_address, req.is_write));
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.granted, rsp.hit, rsp.fault, rsp.writeback, rsp.frame_index};
				if (outcome_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, got.granted);
						fail_count++;
					end
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						fail_count++;
					end
					if (got.fault !== want.fault) begin
						$error("fault: expected %0d, got %0d", want.fault, got.fault);
						fail_count++;
					end
					if (got.writeback !== want.writeback) begin
						$error("writeback: expected %0d, got %0d", want.writeback,
							got.writeback);
						fail_count++;
					end
					if (got.frame_index !== want.frame_index) begin
						$error("frame_index: expected %0d, got %0d", want.frame_index,
							got.frame_index);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== bench/enhanced_second_chance_frames_top_tb.sv =====
// Stimulus and verdict for the enhanced second chance frame table.
`timescale 1ns / 1ps
module enhanced_second_chance_frames_top_tb;
	import escf_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 38;
	int take_idle_pct = 56;
	int fail_count;
	int pending;
	int quiet_cycles = 0;
	logic [7:0] owner_pool [8];
	logic [19:0] page_pool [24];

	escf_req_if req ();
	escf_rsp_if rsp ();
	escf_cfg_if cfg ();

	enhanced_second_chance_frames_top dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	escf_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.sink), .cfg(cfg.sink),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.req_type = 1'b0;
		req.owner_id = '0;
		req.byte_address = '0;
		req.is_write = 1'b0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
	end

	// result side back-pressure
	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= take_idle_pct);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// valid is left high after the word is taken; the next call or the caller drops it
	task automatic send_word(input req_kind_t kind, input logic [7:0] who,
			input logic [31:0] addr, input logic wr);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.owner_id <= who;
		req.byte_address <= addr;
		req.is_write <= wr;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic write_limit(input logic [7:0] lim);
		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= lim;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly reuse a small set of owners and pages so hits, evictions and refusals occur
	task automatic random_burst(input int n);
		logic [31:0] addr;
		logic [7:0] who;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			who = ($urandom_range(9) == 0) ? 8'($urandom) : owner_pool[$urandom_range(7)];
			addr = $urandom;
			if (pick < 75)
				addr[31:12] = page_pool[$urandom_range(23)];
			else if (pick < 80)
				addr[31:12] = 20'($urandom_range(127));
			if (pick >= 94)
				send_word(REQ_TERMINATE, who, addr, 1'($urandom));
			else
				send_word(REQ_ACCESS, who, addr, 1'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			owner_pool[i] = 8'($urandom_range(255, 1));
		owner_pool[0] = 8'd255;
		owner_pool[1] = 8'd1;
		for (int i = 0; i < 24; i++)
			page_pool[i] = 20'($urandom);
		page_pool[0] = 20'hFFFFF;
		page_pool[1] = 20'h00000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: owner zero, extremes, hit by another owner, terminate
		send_word(REQ_ACCESS, 8'd0, 32'h1234_5000, 1'b1);
		send_word(REQ_TERMINATE, 8'd0, 32'h0, 1'b0);
		send_word(REQ_ACCESS, 8'd1, 32'h0000_0000, 1'b0);
		send_word(REQ_ACCESS, 8'd255, 32'hFFFF_FFFF, 1'b1);
		send_word(REQ_ACCESS, 8'd2, 32'hFFFF_F000, 1'b0);
		send_word(REQ_ACCESS, 8'd1, 32'h0000_0FFF, 1'b1);
		send_word(REQ_TERMINATE, 8'd2, 32'hFFFF_FFFF, 1'b1);
		send_word(REQ_TERMINATE, 8'd77, 32'h0, 1'b0);
		// fill past 64 frames to force victims
		for (int i = 0; i < 70; i++)
			send_word(REQ_ACCESS, 8'd3 + 8'(i % 4), 32'(i + 16) << 12, 1'(i % 3 == 0));
		write_limit(8'd0);
		send_word(REQ_ACCESS, 8'd200, 32'hABCD_E000, 1'b0);
		send_word(REQ_ACCESS, 8'd3, 32'h0001_0000, 1'b1);
		write_limit(8'd1);
		random_burst(150);
		write_limit(8'd255);
		random_burst(350);
		write_limit(8'd4);
		random_burst(150);

		send_idle_pct = 56;
		take_idle_pct = 38;
		write_limit(8'd16);
		random_burst(350);
		send_idle_pct = 0;
		take_idle_pct = 0;
		write_limit(8'd128);
		random_burst(380);

		req.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/escf_pkg.sv
hw/rtl/escf_if.sv
hw/rtl/escf_ctrl.sv
hw/rtl/escf_dp.sv
hw/rtl/enhanced_second_chance_frames_top.sv
bench/escf_checker.sv
bench/enhanced_second_chance_frames_top_tb.sv
